// ===== hw/rtl/idpr_pkg.sv =====
`default_nettype none

package idpr_pkg;

    localparam int LANES  = 4;
    localparam int LANE_W = $clog2(LANES);
    localparam int ACC_W  = 27;
    localparam int GAIN_W = 32;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 2;

    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);

    // saturation bounds, wide for compare and byte for the result
    localparam logic signed [GAIN_W-1:0] SAT_HIGH_W = 32'sd127;
    localparam logic signed [GAIN_W-1:0] SAT_LOW_W  = -32'sd128;
    localparam logic [BYTE_W-1:0]        SAT_HIGH_B = 8'h7F;
    localparam logic [BYTE_W-1:0]        SAT_LOW_B  = 8'h80;

    typedef logic [CFG_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_GAIN  = 2'd0;
    localparam t_cfg_idx CFG_SHIFT = 2'd1;
    localparam t_cfg_idx CFG_RELU  = 2'd2;

    localparam logic signed [GAIN_W-1:0] GAIN_RST  = 32'sd1;
    localparam logic [4:0]               SHIFT_RST = 5'd8;

    typedef logic [LANES-1:0][BYTE_W-1:0] t_lane_bytes;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_MUL,
        ST_QNT
    } t_state;

    typedef struct packed {
        logic              acc;
        logic              mul;
        logic              qnt;
        logic [LANE_W-1:0] lane;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hw/rtl/idpr_dp.sv =====
`default_nettype none

module idpr_dp
    import idpr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire t_lane_bytes i_weight,
    input  wire t_lane_bytes i_activation,
    input  wire logic        i_cfg_we,
    input  wire t_cfg_idx    i_cfg_index,
    input  wire logic [GAIN_W-1:0] i_cfg_data,
    output t_lane_bytes      o_result
);

    logic signed [GAIN_W-1:0] r_gain;
    logic [4:0]               r_shift;
    logic                     r_relu;

    logic signed [ACC_W-1:0]  r_acc [LANES];
    logic signed [GAIN_W-1:0] r_prod;
    t_lane_bytes              r_res;

    logic signed [2*BYTE_W-1:0]      w_mac [LANES];
    logic signed [GAIN_W-1:0]        w_full;
    logic signed [GAIN_W-1:0]        w_shr;
    logic [BYTE_W-1:0]               w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RST;
            r_shift <= SHIFT_RST;
            r_relu  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAIN:  r_gain  <= i_cfg_data;
                CFG_SHIFT: r_shift <= i_cfg_data[4:0];
                CFG_RELU:  r_relu  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int n = 0; n < LANES; n++) begin
            w_mac[n] = $signed(i_weight[n]) * $signed(i_activation[n]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < LANES; n++) begin
                r_acc[n] <= '0;
            end
        end else if (i_cmd.acc) begin
            for (int n = 0; n < LANES; n++) begin
                r_acc[n] <= r_acc[n] + {{(ACC_W-2*BYTE_W){w_mac[n][2*BYTE_W-1]}}, w_mac[n]};
            end
        end else if (i_cmd.qnt) begin
            r_acc[i_cmd.lane] <= '0;
        end
    end

    // one shared multiplier, low 32 bits kept
    assign w_full = GAIN_W'(r_acc[i_cmd.lane]) * r_gain;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= w_full;
        end
    end

    always_comb begin
        w_shr = r_prod >>> r_shift;
        if (r_prod[GAIN_W-1]) begin
            if (r_relu) begin
                w_q = '0;
            end else if (w_shr < SAT_LOW_W) begin
                w_q = SAT_LOW_B;
            end else begin
                w_q = w_shr[BYTE_W-1:0];
            end
        end else if (w_shr > SAT_HIGH_W) begin
            w_q = SAT_HIGH_B;
        end else begin
            w_q = w_shr[BYTE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.qnt) begin
            r_res[i_cmd.lane] <= w_q;
        end
    end

    assign o_result = r_res;

endmodule

`default_nettype wire

// ===== hw/rtl/idpr_ctrl.sv =====
`default_nettype none

module idpr_ctrl
    import idpr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_end_of_vector,
    input  wire logic i_out_stall,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);

    t_state            r_state;
    t_state            n_state;
    logic [LANE_W-1:0] r_lane;
    logic [LANE_W-1:0] n_lane;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_in_acc;

    // a final beat waits until the previous result has left
    assign o_in_stall = (r_state != ST_ACC) || (i_end_of_vector && r_out_valid);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACC: begin
                if (w_in_acc && i_end_of_vector) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_QNT;
            ST_QNT: begin
                if (r_lane == LAST_LANE) begin
                    n_state = ST_ACC;
                end else begin
                    n_state = ST_MUL;
                end
            end
            default: n_state = ST_ACC;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.lane  = r_lane;
        n_lane      = r_lane;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_ACC: begin
                o_cmd.acc = w_in_acc;
                n_lane    = '0;
            end
            ST_MUL: o_cmd.mul = 1'b1;
            ST_QNT: begin
                o_cmd.qnt = 1'b1;
                n_lane    = r_lane + LANE_W'(1);
                if (r_lane == LAST_LANE) begin
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACC;
            r_lane      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lane      <= n_lane;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_valid_after_last_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_QNT && r_lane == LAST_LANE))
        else $error("result valid without finishing the last lane");

    a_final_beat_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_end_of_vector) |-> !r_out_valid)
        else $error("final beat taken while a result is pending");

    a_mul_then_qnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> (r_state == ST_QNT && $stable(r_lane)))
        else $error("requantize step lost its lane");

    a_start_lane_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC && w_in_acc && i_end_of_vector)
            |=> (r_state == ST_MUL && r_lane == '0))
        else $error("requantize pass did not start at lane zero");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/int8_dot_product_requantize.sv =====
// operation: every taken beat is added into the accumulators; after the end-marked
//   beat is taken, each lane in turn passes a multiply step on one shared multiplier
//   (27-bit accumulator by 32-bit gain) and a requantize step, then o_out_valid rises
// throughput: 1 beat per cycle in a vector; stalls in requantize or on a pending result
// reset: synchronous active low; clears accumulators, gain=1, right_shift=8, relu off
`default_nettype none

module int8_dot_product_requantize
    import idpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic signed [7:0] i_weight_lane0,
    input  wire logic signed [7:0] i_weight_lane1,
    input  wire logic signed [7:0] i_weight_lane2,
    input  wire logic signed [7:0] i_weight_lane3,
    input  wire logic signed [7:0] i_activation_lane0,
    input  wire logic signed [7:0] i_activation_lane1,
    input  wire logic signed [7:0] i_activation_lane2,
    input  wire logic signed [7:0] i_activation_lane3,
    input  wire logic              i_end_of_vector,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic signed [7:0]      o_result_lane0,
    output logic signed [7:0]      o_result_lane1,
    output logic signed [7:0]      o_result_lane2,
    output logic signed [7:0]      o_result_lane3,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data
);

    t_cmd        w_cmd;
    t_lane_bytes w_weight;
    t_lane_bytes w_activation;
    t_lane_bytes w_result;

    assign w_weight     = {i_weight_lane3, i_weight_lane2, i_weight_lane1, i_weight_lane0};
    assign w_activation = {i_activation_lane3, i_activation_lane2,
                           i_activation_lane1, i_activation_lane0};

    idpr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_end_of_vector (i_end_of_vector),
        .i_out_stall     (i_out_stall),
        .o_in_stall      (o_in_stall),
        .o_out_valid     (o_out_valid),
        .o_cmd           (w_cmd)
    );

    idpr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_weight     (w_weight),
        .i_activation (w_activation),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_result     (w_result)
    );

    assign o_result_lane0 = w_result[0];
    assign o_result_lane1 = w_result[1];
    assign o_result_lane2 = w_result[2];
    assign o_result_lane3 = w_result[3];

endmodule

`default_nettype wire

// ===== test/int8_dot_product_requantize_tb.sv =====
module int8_dot_product_requantize_tb
    import idpr_pkg::*;
();

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 16;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 8;
    localparam int BEATS_PER_PHASE = 120;
    localparam int LONG_RUN_BEATS  = 200;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_AFTER      = 30;
    localparam int IDLE_PCT        = 22;
    localparam int CALM_PHASE      = 2;
    localparam int MAX_REPORTS     = 10;

    // index with no register behind it, writes must be dropped
    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    typedef struct packed {
        t_lane_bytes weight;
        t_lane_bytes act;
        logic        last;
    } t_vec_beat;

    class dot_product_model;
        logic signed [GAIN_W-1:0] gain;
        logic [4:0]               shift;
        logic                     relu;
        logic [ACC_W-1:0]         acc [LANES];
        t_lane_bytes              expected_q [$];
        int                       mismatches;
        int                       results_seen;

        function new();
            gain         = GAIN_RST;
            shift        = SHIFT_RST;
            relu         = 1'b0;
            foreach (acc[n]) acc[n] = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] data);
            case (idx)
                CFG_GAIN:  gain  = data;
                CFG_SHIFT: shift = data[4:0];
                CFG_RELU:  relu  = data[0];
                default: ;
            endcase
        endfunction

        function logic [BYTE_W-1:0] requantize_lane(logic [ACC_W-1:0] a);
            logic signed [GAIN_W-1:0] wide;
            logic signed [GAIN_W-1:0] prod;
            logic signed [GAIN_W-1:0] shifted;
            wide    = {{(GAIN_W-ACC_W){a[ACC_W-1]}}, a};
            // low 32 bits of the product, wrapping
            prod    = wide * gain;
            shifted = prod >>> shift;
            if (prod < 0) begin
                if (relu) return '0;
                if (shifted < SAT_LOW_W) return SAT_LOW_B;
                return shifted[BYTE_W-1:0];
            end
            if (shifted > SAT_HIGH_W) return SAT_HIGH_B;
            return shifted[BYTE_W-1:0];
        endfunction

        function void note_beat(t_vec_beat b);
            logic signed [15:0] prod;
            t_lane_bytes        res;
            for (int n = 0; n < LANES; n++) begin
                prod   = $signed(b.weight[n]) * $signed(b.act[n]);
                acc[n] = acc[n] + {{(ACC_W-16){prod[15]}}, prod};
            end
            if (b.last) begin
                for (int n = 0; n < LANES; n++) begin
                    res[n] = requantize_lane(acc[n]);
                    acc[n] = '0;
                end
                expected_q.push_back(res);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void check_result(t_lane_bytes got);
            t_lane_bytes want;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result beat with nothing pending: %h", got);
                return;
            end
            want = expected_q.pop_front();
            for (int n = 0; n < LANES; n++) begin
                if (got[n] !== want[n]) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result_lane%0d mismatch: expected %0d, got %0d",
                                 n, $signed(want[n]), $signed(got[n]));
                end
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    wire               in_stall;
    t_lane_bytes       weight    = '0;
    t_lane_bytes       act       = '0;
    logic              eov       = 1'b0;
    wire               out_valid;
    logic              out_stall = 1'b0;
    wire [BYTE_W-1:0]  result_lane [LANES];
    logic              cfg_we    = 1'b0;
    t_cfg_idx          cfg_index = CFG_GAIN;
    logic [31:0]       cfg_data  = '0;

    bit                calm        = 1'b0;
    int                cycle_count = 0;
    dot_product_model  model       = new();

    int8_dot_product_requantize u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_weight_lane0     (weight[0]),
        .i_weight_lane1     (weight[1]),
        .i_weight_lane2     (weight[2]),
        .i_weight_lane3     (weight[3]),
        .i_activation_lane0 (act[0]),
        .i_activation_lane1 (act[1]),
        .i_activation_lane2 (act[2]),
        .i_activation_lane3 (act[3]),
        .i_end_of_vector    (eov),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_result_lane0     (result_lane[0]),
        .o_result_lane1     (result_lane[1]),
        .o_result_lane2     (result_lane[2]),
        .o_result_lane3     (result_lane[3]),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off to back the block up
    initial begin : result_sink
        int hold_left = 0;
        bit hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n) begin
                if (out_valid && !out_stall)
                    model.check_result({result_lane[3], result_lane[2],
                                        result_lane[1], result_lane[0]});
                if (!hold_done && model.results_seen >= HOLD_AFTER) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    out_stall <= 1'b1;
                end else begin
                    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
                end
            end
        end
    end

    task automatic send_beat(input t_vec_beat b);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        weight   <= b.weight;
        act      <= b.act;
        eov      <= b.last;
        do @(posedge clk); while (in_stall);
        model.note_beat(b);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (model.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        model.write_reg(idx, data);
    endtask

    task automatic apply_settings(input logic [31:0] g, input logic [31:0] sh,
                                  input logic [31:0] rl);
        write_reg(CFG_UNUSED, $urandom);
        write_reg(CFG_GAIN, g);
        write_reg(CFG_SHIFT, sh);
        write_reg(CFG_RELU, rl);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_random_settings();
        logic [31:0] g;
        logic [31:0] sh;
        logic [31:0] rl;
        case ($urandom_range(5))
            0: g = 32'h8000_0000;
            1: g = 32'h7FFF_FFFF;
            2: g = $urandom;
            default: begin
                g = $urandom_range(1, 1 << $urandom_range(0, 14));
                if ($urandom_range(1)) g = -g;
            end
        endcase
        // upper data bits are junk the block must ignore
        sh = $urandom;
        case ($urandom_range(5))
            0: sh[4:0] = 5'd0;
            1: sh[4:0] = 5'd31;
            2: ;
            default: sh[4:0] = 5'($urandom_range(4, 20));
        endcase
        rl = $urandom;
        apply_settings(g, sh, rl);
    endtask

    function automatic logic [BYTE_W-1:0] random_byte();
        case ($urandom_range(9))
            0: return 8'h80;
            1: return 8'h7F;
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_directed_runs();
        t_vec_beat b;
        // largest positive product on every lane
        b.weight = {4{8'h80}};
        b.act    = {4{8'h80}};
        b.last   = 1'b1;
        send_beat(b);
        // most negative product
        b.act = {4{8'h7F}};
        send_beat(b);
        // mixed lanes over a two-beat vector
        b.weight = {8'hFF, 8'h00, 8'h7F, 8'h80};
        b.act    = {8'h01, 8'h4D, 8'h80, 8'h80};
        b.last   = 1'b0;
        send_beat(b);
        b.weight = {8'h7F, 8'h80, 8'h01, 8'h7F};
        b.act    = {8'h7F, 8'h80, 8'hFF, 8'h7F};
        b.last   = 1'b1;
        send_beat(b);
        b.weight = '0;
        b.act    = '0;
        send_beat(b);
    endtask

    // one long vector that drives every accumulator far from zero
    task automatic send_overlong_run();
        t_vec_beat b;
        b.weight = {4{8'h80}};
        b.act    = {8'h7F, 8'h7F, 8'h80, 8'h80};
        for (int k = 0; k < LONG_RUN_BEATS; k++) begin
            b.last = (k == LONG_RUN_BEATS - 1);
            send_beat(b);
        end
    endtask

    task automatic send_random_phase();
        t_vec_beat b;
        int        sent = 0;
        int        len;
        while (sent < BEATS_PER_PHASE) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                for (int n = 0; n < LANES; n++) begin
                    b.weight[n] = random_byte();
                    b.act[n]    = random_byte();
                end
                b.last = (k == len - 1);
                send_beat(b);
            end
            sent += len;
        end
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings first, then zero shift, gain overflow and relu, min gain
        send_directed_runs();
        drain_results();
        apply_settings(32'hFFFF_FFFF, 32'd0, 32'd0);
        send_directed_runs();
        drain_results();
        apply_settings(32'h7FFF_FFFF, 32'd31, 32'd1);
        send_directed_runs();
        drain_results();
        apply_settings(32'h8000_0000, 32'd0, 32'd0);
        send_directed_runs();
        drain_results();

        apply_settings(32'd1, 32'd0, 32'd0);
        send_overlong_run();
        drain_results();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            calm = (p == CALM_PHASE);
            apply_random_settings();
            send_random_phase();
            drain_results();
        end
        calm = 1'b0;

        if (model.mismatches == 0 && model.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/idpr_pkg.sv
hw/rtl/idpr_dp.sv
hw/rtl/idpr_ctrl.sv
hw/rtl/int8_dot_product_requantize.sv
test/int8_dot_product_requantize_tb.sv
